[sv/bsfa_pkg.sv]
// Package for the bilinear splat fade accumulator.
// Holds payload structs, plate geometry and fixed-point constants; no dependencies.
`timescale 1ns / 1ps
package bsfa_pkg;
    localparam int PLATE_WIDTH  = 480;
    localparam int PLATE_HEIGHT = 360;
    localparam int CELLS        = PLATE_WIDTH * PLATE_HEIGHT;
    localparam int ADDR_W       = $clog2(CELLS);
    localparam int ACC_W        = 24;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic signed [20:0] HALO_OFFSET = 21'sd410;
    localparam logic [15:0] HALO_SCALE  = 16'd19661;
    localparam logic [15:0] DECAY_RESET = 16'd65379;
    localparam logic REQ_DEPOSIT = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [19:0] x_pos;
        logic signed [19:0] y_pos;
        logic [15:0]        red_in;
        logic [15:0]        green_in;
        logic [15:0]        blue_in;
        logic               halo;
        logic [17:0]        pixel_index;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  red_byte;
        logic [7:0]  green_byte;
        logic [7:0]  blue_byte;
        logic [17:0] pixel_out;
    } out_beat_t;

    typedef struct packed {
        logic [ACC_W-1:0] r;
        logic [ACC_W-1:0] g;
        logic [ACC_W-1:0] b;
    } cell_t;
endpackage

[sv/bsfa_plate_ram.sv]
// Plate memory of the splat accumulator: one RGB cell per word, one read and one write port.
// Depends on bsfa_pkg.
`timescale 1ns / 1ps
module bsfa_plate_ram
    import bsfa_pkg::*;
(
    input  logic              aclk,
    input  logic [ADDR_W-1:0] rd_addr,
    output cell_t             rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  cell_t             wr_data
);
    cell_t mem [CELLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[sv/bilinear_splat_fade_accumulator.sv]
// Top level of the bilinear splat fade accumulator: control sequencer and datapath.
// Depends on bsfa_pkg and bsfa_plate_ram.
`timescale 1ns / 1ps
//
//  channel   direction  payload     handshake
//  s_        in         in_beat_t   s_valid / s_ready
//  m_        out        out_beat_t  m_valid / m_ready
//  cfg       in         16 bits     cfg_we (no wait)
//
// After reset a clearing pass writes zero to all 172800 plate cells, one a
// cycle, and no beat is taken until it ends. A deposit then places each tap
// in turn and makes four plate read-modify-writes per tap that lands, each
// stepping through read, wait for data, modify and write; a dropped tap is
// skipped. A read-out steps through the same read, wait, modify and write and
// offers its result in the write step. The next beat can be taken once the
// block is idle again. The wait step covers the registered read of the plate
// memory, and a single read-modify-write is kept in flight at a time.
// A result waits in the output register; the next beat is accepted once it
// is taken.
module bilinear_splat_fade_accumulator
    import bsfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data,
    input  logic      cfg_we,
    input  logic [15:0] cfg_data
);
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_TAP   = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_MOD   = 7'b0100000,
        ST_WRITE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    in_beat_t req_reg;
    logic [15:0] decay_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [2:0] tap_reg;       // 0 core, 1..4 halo taps
    logic [1:0] corner_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [7:0] fx_reg, fy_reg;
    logic [15:0] cr_reg, cg_reg, cb_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [16:0] w_reg;
    cell_t rd_data, wr_data_reg;
    logic wr_en_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic m_valid_reg;
    out_beat_t m_data_reg;
    cell_t mod_reg;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Tap position.
    logic signed [20:0] tx, ty, xb, yb;
    logic signed [12:0] ix, iy;
    logic tap_ok;
    always_comb begin
        tx = 21'(req_reg.x_pos);
        ty = 21'(req_reg.y_pos);
        case (tap_reg)
            3'd1: tx = tx - HALO_OFFSET;
            3'd2: tx = tx + HALO_OFFSET;
            3'd3: ty = ty - HALO_OFFSET;
            3'd4: ty = ty + HALO_OFFSET;
            default: ;
        endcase
        xb = tx;
        yb = ty;
        ix = xb[20:8];
        iy = yb[20:8];
        tap_ok = !ix[12] && !iy[12] && (ix <= 13'(PLATE_WIDTH - 2))
                 && (iy <= 13'(PLATE_HEIGHT - 2));
    end

    function automatic logic [15:0] hscale(input logic [15:0] c);
        logic [31:0] p;
        p = c * HALO_SCALE + 32'd32768;
        return p[31:16];
    endfunction

    function automatic logic [ACC_W-1:0] addsat(input logic [ACC_W-1:0] v,
                                                input logic [15:0] c,
                                                input logic [16:0] w);
        logic [32:0] p;
        logic [ACC_W:0] s;
        p = 33'(c) * 33'(w);
        s = {1'b0, v} + (ACC_W+1)'(p[32:16]);
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    function automatic logic [7:0] tone(input logic [ACC_W-1:0] v);
        logic [31:0] p;
        p = v * 32'd255;
        return (p[31:16] > 16'd255) ? 8'hFF : p[23:16];
    endfunction

    function automatic logic [ACC_W-1:0] fade(input logic [ACC_W-1:0] v,
                                              input logic [15:0] d);
        logic [39:0] p;
        p = 40'(v) * 40'(d);
        return p[39:16];
    endfunction

    logic [ADDR_W-1:0] rd_addr;
    assign rd_addr = addr_reg;

    bsfa_plate_ram u_ram (
        .aclk(aclk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en_reg), .wr_addr(wr_addr_reg), .wr_data(wr_data_reg)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_DEPOSIT)
                    state_next = ST_TAP;
                else if (32'(s_data.pixel_index) < 32'(CELLS))
                    state_next = ST_READ;
            end
            ST_TAP: begin
                if (tap_ok) state_next = ST_READ;
                else if (tap_reg == 3'd0 && !req_reg.halo) state_next = ST_IDLE;
                else if (tap_reg == 3'd4) state_next = ST_IDLE;
            end
            ST_READ:  state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_MOD;
            ST_MOD:   state_next = ST_WRITE;
            ST_WRITE: begin
                if (req_reg.req_type == REQ_READ) state_next = ST_IDLE;
                else if (corner_reg != 2'd3) state_next = ST_READ;
                else if (tap_reg == 3'd4 || !req_reg.halo) state_next = ST_IDLE;
                else state_next = ST_TAP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            decay_reg   <= DECAY_RESET;
            m_valid_reg <= 1'b0;
            wr_en_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) decay_reg <= cfg_data;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            // The plate is written in the cycle after a clear or write step.
            wr_en_reg <= (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
            case (state_reg)
                ST_CLEAR: begin
                    wr_addr_reg <= clr_reg;
                    wr_data_reg <= '0;
                    clr_reg     <= clr_reg + ADDR_W'(1);
                end
                ST_IDLE: if (s_valid && s_ready) begin
                    req_reg    <= s_data;
                    tap_reg    <= 3'd0;
                    cr_reg     <= s_data.red_in;
                    cg_reg     <= s_data.green_in;
                    cb_reg     <= s_data.blue_in;
                    if (s_data.req_type == REQ_READ) begin
                        addr_reg <= s_data.pixel_index[ADDR_W-1:0];
                    end
                end
                ST_TAP: begin
                    if (tap_reg == 3'd0 && req_reg.halo && !tap_ok) begin
                        cr_reg <= hscale(cr_reg);
                        cg_reg <= hscale(cg_reg);
                        cb_reg <= hscale(cb_reg);
                    end
                    if (!tap_ok) tap_reg <= tap_reg + 3'd1;
                    fx_reg     <= xb[7:0];
                    fy_reg     <= yb[7:0];
                    base_reg   <= ADDR_W'(32'(iy) * PLATE_WIDTH + 32'(ix));
                    corner_reg <= 2'd3;
                end
                ST_READ: if (req_reg.req_type == REQ_DEPOSIT) begin
                    corner_reg <= corner_reg + 2'd1;
                end
                ST_WAIT: ;
                ST_MOD: begin
                    if (req_reg.req_type == REQ_DEPOSIT) begin
                        mod_reg.r <= addsat(rd_data.r, cr_reg, w_reg);
                        mod_reg.g <= addsat(rd_data.g, cg_reg, w_reg);
                        mod_reg.b <= addsat(rd_data.b, cb_reg, w_reg);
                    end else begin
                        mod_reg.r <= fade(rd_data.r, decay_reg);
                        mod_reg.g <= fade(rd_data.g, decay_reg);
                        mod_reg.b <= fade(rd_data.b, decay_reg);
                        m_valid_reg         <= 1'b1;
                        m_data_reg.red_byte   <= tone(rd_data.r);
                        m_data_reg.green_byte <= tone(rd_data.g);
                        m_data_reg.blue_byte  <= tone(rd_data.b);
                        m_data_reg.pixel_out  <= req_reg.pixel_index;
                    end
                end
                ST_WRITE: begin
                    wr_addr_reg <= addr_reg;
                    wr_data_reg <= mod_reg;
                    if (req_reg.req_type == REQ_DEPOSIT && corner_reg == 2'd3) begin
                        if (tap_reg == 3'd0) begin
                            cr_reg <= hscale(cr_reg);
                            cg_reg <= hscale(cg_reg);
                            cb_reg <= hscale(cb_reg);
                        end
                        tap_reg <= tap_reg + 3'd1;
                    end
                end
                default: ;
            endcase
            // Address and weight of the next corner, set as a read is issued.
            if (state_next == ST_READ && req_reg.req_type == REQ_DEPOSIT
                && state_reg != ST_IDLE) begin
                if (state_reg == ST_TAP) begin
                    addr_reg <= ADDR_W'(32'(iy) * PLATE_WIDTH + 32'(ix));
                    w_reg    <= 17'((9'd256 - 9'(xb[7:0])) * (9'd256 - 9'(yb[7:0])));
                end else begin
                    addr_reg <= base_reg + ((corner_reg + 2'd1) == 2'd1 ? ADDR_W'(1) :
                                (corner_reg + 2'd1) == 2'd2 ? ADDR_W'(PLATE_WIDTH) :
                                ADDR_W'(PLATE_WIDTH + 1));
                    w_reg    <= 17'(((corner_reg + 2'd1) == 2'd1 ||
                                     (corner_reg + 2'd1) == 2'd3 ?
                                     {1'b0, fx_reg} : 9'd256 - 9'(fx_reg)) *
                                    ((corner_reg + 2'd1) >= 2'd2 ?
                                     {1'b0, fy_reg} : 9'd256 - 9'(fy_reg)));
                end
            end
        end
    end

    // A write to the plate only happens while clearing or in the write step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_reg |-> ($past(state_reg) == ST_CLEAR || $past(state_reg) == ST_WRITE))
        else $error("plate write outside clear or write step");
    // No beat is taken during the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input ready during clear");
    // A result appears only after a modify step of a read-out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_MOD
                                && req_reg.req_type == REQ_READ))
        else $error("result without read-out");
endmodule
